// ===== design/inv3_pkg.sv =====
// Shared widths, constants, cofactor index tables and types for the 3x3 matrix inverse.
`default_nettype none
package inv3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int N_EL      = 9;
	localparam int N_ROW     = 3;
	localparam int ELEM_W    = 32;
	localparam int HALF_W    = 32;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int COF_W     = PROD_W + 1;
	localparam int MAG_W     = PROD_W;
	localparam int DMAG_W    = MAG_W + HALF_W;
	localparam int DET_W     = DMAG_W + 1;
	localparam int QUO_W     = 32;
	localparam int NUM_W     = MAG_W + 2 * FRAC_BITS;
	localparam int CMP_W     = DMAG_W + QUO_W;

	localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

	// Cofactor k (row-major) is flip ? (c*d - a*b) : (a*b - c*d), indexes into the elements.
	localparam int COF_A [0:N_EL-1] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
	localparam int COF_B [0:N_EL-1] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
	localparam int COF_C [0:N_EL-1] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
	localparam int COF_D [0:N_EL-1] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
	localparam bit COF_FLIP [0:N_EL-1] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

	typedef struct packed {
		logic signed [QUO_W-1:0] value;
		logic                    clip;
	} div_res_t;

endpackage
`default_nettype wire

// ===== design/inv3_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, signed and saturated result.
`default_nettype none
module inv3_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [inv3_pkg::NUM_W-1:0]    num,
	input  wire logic [inv3_pkg::DMAG_W-1:0]   den,
	input  wire logic                          neg,
	output inv3_pkg::div_res_t                 res
);
	import inv3_pkg::*;

	logic [NUM_W-1:0]  rem_s [0:QUO_W];
	logic [QUO_W-1:0]  quo_s [0:QUO_W];
	logic [DMAG_W-1:0] den_s [0:QUO_W];
	logic [QUO_W:0]    neg_s;
	logic [QUO_W:0]    ovf_s;

	// The first stage flags a quotient that does not fit in the quotient width.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << QUO_W);
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		localparam int B = QUO_W - k;
		logic [CMP_W-1:0] shd;
		logic             ge;
		assign shd = CMP_W'(den_s[k-1]) << B;
		assign ge  = CMP_W'(rem_s[k-1]) >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_s[k-1] - shd[NUM_W-1:0] : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QUO_W'(ge) << B);
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	logic [QUO_W-1:0] q;
	assign q = quo_s[QUO_W];

	always_comb begin
		if (!neg_s[QUO_W]) begin
			res.clip  = ovf_s[QUO_W] || (q > POS_MAX);
			res.value = res.clip ? $signed(POS_MAX) : $signed(q);
		end else begin
			res.clip  = ovf_s[QUO_W] || (q > NEG_MAX);
			res.value = res.clip ? $signed(NEG_MAX) : $signed(-q);
		end
	end

endmodule
`default_nettype wire

// ===== design/matrix_inverse_3x3_core.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverse by the adjugate.
`default_nettype none
// One 3x3 matrix of signed Q16.16 elements enters per beat and the block accepts a new beat
// in every cycle with in_stall low; each beat returns its inverse, one beat out per beat in.
// The front end takes six stages (element products, cofactors, cofactor-element partial
// products, signed terms, determinant, determinant magnitude), then nine restoring dividers
// work in parallel, each with an overflow check stage and one stage per quotient bit, and a
// final output register holds the beat. The quotient-bit stages of the dividers set the
// latency. Elements are rounded toward zero and clipped to the 32-bit range, with saturated
// raised when any element was clipped; a zero determinant gives all-zero elements and raises
// singular. The whole pipeline holds while a finished beat waits at the output, and in_stall
// is raised in those cycles. Reset clears only the valid bits.
module matrix_inverse_3x3_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a00,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a01,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a02,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a10,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a11,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a12,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a20,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a21,
	input  wire logic signed [inv3_pkg::ELEM_W-1:0] a22,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [inv3_pkg::QUO_W-1:0]      r00,
	output logic signed [inv3_pkg::QUO_W-1:0]      r01,
	output logic signed [inv3_pkg::QUO_W-1:0]      r02,
	output logic signed [inv3_pkg::QUO_W-1:0]      r10,
	output logic signed [inv3_pkg::QUO_W-1:0]      r11,
	output logic signed [inv3_pkg::QUO_W-1:0]      r12,
	output logic signed [inv3_pkg::QUO_W-1:0]      r20,
	output logic signed [inv3_pkg::QUO_W-1:0]      r21,
	output logic signed [inv3_pkg::QUO_W-1:0]      r22,
	output logic                                   singular,
	output logic                                   saturated
);
	import inv3_pkg::*;

	// The pipeline moves as a whole unless the output register holds an untaken beat.
	logic adv;
	logic out_valid_q;
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	logic signed [ELEM_W-1:0] x_in [0:N_EL-1];
	assign x_in[0] = a00;
	assign x_in[1] = a01;
	assign x_in[2] = a02;
	assign x_in[3] = a10;
	assign x_in[4] = a11;
	assign x_in[5] = a12;
	assign x_in[6] = a20;
	assign x_in[7] = a21;
	assign x_in[8] = a22;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [QUO_W:0] vld_d;
	logic [QUO_W:0] sing_d;

	// Stage 1: the eighteen element products, exact in 64 bits.
	logic signed [PROD_W-1:0] pab_s1 [0:N_EL-1];
	logic signed [PROD_W-1:0] pcd_s1 [0:N_EL-1];
	logic signed [ELEM_W-1:0] xr_s1  [0:N_ROW-1];
	logic signed [ELEM_W-1:0] xr_s2  [0:N_ROW-1];

	for (genvar k = 0; k < N_EL; k++) begin : g_prod
		always_ff @(posedge clk) begin
			if (adv) begin
				pab_s1[k] <= x_in[COF_A[k]] * x_in[COF_B[k]];
				pcd_s1[k] <= x_in[COF_C[k]] * x_in[COF_D[k]];
			end
		end
	end

	for (genvar k = 0; k < N_ROW; k++) begin : g_row
		always_ff @(posedge clk) begin
			if (adv) begin
				xr_s1[k] <= x_in[k];
				xr_s2[k] <= xr_s1[k];
			end
		end
	end

	// Stage 2: cofactors as sign and magnitude; a zero cofactor is never negative.
	logic [MAG_W-1:0] cm_s2 [0:N_EL-1];
	logic [MAG_W-1:0] cm_s3 [0:N_EL-1];
	logic [MAG_W-1:0] cm_s4 [0:N_EL-1];
	logic [MAG_W-1:0] cm_s5 [0:N_EL-1];
	logic [MAG_W-1:0] cm_s6 [0:N_EL-1];
	logic [N_EL-1:0]  cn_s2, cn_s3, cn_s4, cn_s5, cn_s6;

	for (genvar k = 0; k < N_EL; k++) begin : g_cof
		logic signed [COF_W-1:0] p, q, d;
		logic        [COF_W-1:0] mag;
		assign p   = COF_W'(pab_s1[k]);
		assign q   = COF_W'(pcd_s1[k]);
		assign d   = COF_FLIP[k] ? q - p : p - q;
		assign mag = d[COF_W-1] ? -d : d;
		always_ff @(posedge clk) begin
			if (adv) begin
				cm_s2[k] <= mag[MAG_W-1:0];
				cn_s2[k] <= d[COF_W-1];
				cm_s3[k] <= cm_s2[k];
				cm_s4[k] <= cm_s3[k];
				cm_s5[k] <= cm_s4[k];
				cm_s6[k] <= cm_s5[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cn_s3 <= cn_s2;
			cn_s4 <= cn_s3;
			cn_s5 <= cn_s4;
			cn_s6 <= cn_s5;
		end
	end

	// Stages 3 and 4: the first-row terms of the determinant, split into two 32x32 products.
	logic [PROD_W-1:0]       pl_s3 [0:N_ROW-1];
	logic [PROD_W-1:0]       ph_s3 [0:N_ROW-1];
	logic [N_ROW-1:0]        sg_s3;
	logic signed [DET_W-1:0] t_s4  [0:N_ROW-1];

	for (genvar k = 0; k < N_ROW; k++) begin : g_term
		logic [ELEM_W-1:0] xm;
		logic [DMAG_W-1:0] tm;
		assign xm = xr_s2[k][ELEM_W-1] ? -xr_s2[k] : xr_s2[k];
		assign tm = (DMAG_W'(ph_s3[k]) << HALF_W) + DMAG_W'(pl_s3[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				pl_s3[k] <= cm_s2[k][HALF_W-1:0] * xm;
				ph_s3[k] <= cm_s2[k][MAG_W-1:HALF_W] * xm;
				sg_s3[k] <= cn_s2[k] ^ xr_s2[k][ELEM_W-1];
				t_s4[k]  <= sg_s3[k] ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
			end
		end
	end

	// Stage 5: the determinant; stage 6: its magnitude, sign and the singular flag.
	logic signed [DET_W-1:0] det_s5;
	logic        [DET_W-1:0] det_abs;
	logic [DMAG_W-1:0]       dmag_s6;
	logic                    dneg_s6;
	logic                    sing_s6;

	assign det_abs = det_s5[DET_W-1] ? -det_s5 : det_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5  <= t_s4[0] + t_s4[1] + t_s4[2];
			dmag_s6 <= det_abs[DMAG_W-1:0];
			dneg_s6 <= det_s5[DET_W-1];
			sing_s6 <= det_s5 == '0;
		end
	end

	// Nine dividers; inverse element (i, j) takes cofactor (j, i).
	div_res_t dres [0:N_EL-1];

	for (genvar o = 0; o < N_EL; o++) begin : g_div
		localparam int CI = (o % N_ROW) * N_ROW + (o / N_ROW);
		inv3_div u_div (
			.clk (clk),
			.en  (adv),
			.num ({cm_s6[CI], {(2 * FRAC_BITS){1'b0}}}),
			.den (dmag_s6),
			.neg (cn_s6[CI] ^ dneg_s6),
			.res (dres[o])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_d <= {sing_d[QUO_W-1:0], sing_s6};
		end
	end

	// Valid bits travel with the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_d       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_d       <= {vld_d[QUO_W-1:0], vld_s6};
			out_valid_q <= vld_d[QUO_W];
		end
	end

	// Output register: a singular matrix forces zeros and no clipping.
	logic signed [QUO_W-1:0] r_q [0:N_EL-1];
	logic                    singular_q;
	logic                    saturated_q;
	logic [N_EL-1:0]         clips;

	for (genvar o = 0; o < N_EL; o++) begin : g_out
		assign clips[o] = dres[o].clip;
		always_ff @(posedge clk) begin
			if (adv) begin
				r_q[o] <= sing_d[QUO_W] ? '0 : dres[o].value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			singular_q  <= sing_d[QUO_W];
			saturated_q <= !sing_d[QUO_W] && (|clips);
		end
	end

	assign out_valid = out_valid_q;
	assign r00       = r_q[0];
	assign r01       = r_q[1];
	assign r02       = r_q[2];
	assign r10       = r_q[3];
	assign r11       = r_q[4];
	assign r12       = r_q[5];
	assign r20       = r_q[6];
	assign r21       = r_q[7];
	assign r22       = r_q[8];
	assign singular  = singular_q;
	assign saturated = saturated_q;

	// A singular beat carries zeros and never reports clipping.
	a_sing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && r00 == '0 && r22 == '0)
		else $error("singular beat with nonzero result or saturation");

	// A zero determinant that moves on is flagged singular in the next stage.
	a_sing_flag: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && adv && det_s5 == '0 |=> sing_s6)
		else $error("zero determinant not flagged singular");

endmodule
`default_nettype wire

// ===== sim/inverse_scoreboard.sv =====
// Scoreboard for the 3x3 matrix inverse: predicts each inverse and checks the output beats.
`timescale 1ns / 100ps

typedef logic [8:0][31:0] mat_t;

typedef struct packed {
	logic [8:0][31:0] r;
	logic             singular;
	logic             saturated;
} inv_res_t;

class inverse_scoreboard;
	inv_res_t expected_q[$];

	// Adjugate over the determinant with exact wide integers, rounded toward zero.
	function inv_res_t invert(mat_t a);
		logic signed [127:0] x[9];
		logic signed [127:0] c[9];
		logic signed [127:0] det;
		logic signed [127:0] q;
		inv_res_t res;
		for (int k = 0; k < 9; k++) begin
			x[k] = $signed(a[k]);
		end
		c[0] = x[4] * x[8] - x[5] * x[7];
		c[1] = x[5] * x[6] - x[3] * x[8];
		c[2] = x[3] * x[7] - x[4] * x[6];
		c[3] = x[2] * x[7] - x[1] * x[8];
		c[4] = x[0] * x[8] - x[2] * x[6];
		c[5] = x[1] * x[6] - x[0] * x[7];
		c[6] = x[1] * x[5] - x[2] * x[4];
		c[7] = x[2] * x[3] - x[0] * x[5];
		c[8] = x[0] * x[4] - x[1] * x[3];
		det = c[0] * x[0] + c[1] * x[1] + c[2] * x[2];
		res = '0;
		if (det == 0) begin
			res.singular = 1'b1;
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				q = (c[j * 3 + i] <<< (2 * inv3_pkg::FRAC_BITS)) / det;
				if (q > 128'sh7FFFFFFF) begin
					res.r[i * 3 + j] = inv3_pkg::POS_MAX;
					res.saturated = 1'b1;
				end else if (q < -128'sh80000000) begin
					res.r[i * 3 + j] = inv3_pkg::NEG_MAX;
					res.saturated = 1'b1;
				end else begin
					res.r[i * 3 + j] = q[31:0];
				end
			end
		end
		return res;
	endfunction

	function void note_matrix(mat_t a);
		expected_q = {expected_q, invert(a)};
	endfunction

	// Returns an empty string on a match, otherwise a description of the bad fields.
	function string check_result(inv_res_t got);
		inv_res_t want;
		string msg;
		msg = "";
		if (expected_q.size() == 0) begin
			return "output beat with no matrix pending";
		end
		want = expected_q.pop_front();
		for (int k = 0; k < 9; k++) begin
			if (got.r[k] !== want.r[k]) begin
				msg = {msg, $sformatf(" r%0d%0d got %h want %h", k / 3, k % 3,
					got.r[k], want.r[k])};
			end
		end
		if (got.singular !== want.singular) begin
			msg = {msg, $sformatf(" singular got %b want %b", got.singular, want.singular)};
		end
		if (got.saturated !== want.saturated) begin
			msg = {msg, $sformatf(" saturated got %b want %b", got.saturated,
				want.saturated)};
		end
		return msg;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

// ===== sim/matrix_inverse_3x3_core_tb.sv =====
// Testbench top for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 100ps

module matrix_inverse_3x3_core_tb;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] EMAX = 32'h7FFF_FFFF;
	localparam logic [31:0] EMIN = 32'h8000_0000;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mat_t in_mat;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic singular;
	logic saturated;

	inverse_scoreboard sb;
	int mismatches;
	int cycles;
	// Set at each rising edge when the input beat was taken; read by the driver at the
	// falling edge, which keeps the handshake free of ordering races.
	bit in_fire;
	// Receiver controls: a forced hold-off length and a flag for stall-free stretches.
	int hold_cycles;
	bit quiet;

	matrix_inverse_3x3_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a00(in_mat[0]), .a01(in_mat[1]), .a02(in_mat[2]),
		.a10(in_mat[3]), .a11(in_mat[4]), .a12(in_mat[5]),
		.a20(in_mat[6]), .a21(in_mat[7]), .a22(in_mat[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.singular(singular), .saturated(saturated)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(string what);
		$display("mismatch at cycle %0d:%s", cycles, what);
		mismatches++;
	endtask

	// Both monitors read the pre-edge values of the handshake, so each beat is seen once.
	always @(posedge clk) begin
		cycles++;
		in_fire = in_valid && !in_stall;
		if (in_fire) begin
			sb.note_matrix(in_mat);
		end
		if (out_valid && !out_stall) begin
			inv_res_t got;
			string msg;
			got.r = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
			got.singular = singular;
			got.saturated = saturated;
			msg = sb.check_result(got);
			if (msg != "") begin
				report(msg);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) begin
			return 0;
		end
		if ($urandom_range(0, 9) < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Receiver: a forced hold-off wins, otherwise random stalls unless a quiet stretch runs.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_left = gap_len();
					out_stall <= (stall_left > 0);
				end else begin
					out_stall <= 1'b1;
				end
				if (stall_left > 0) begin
					stall_left--;
				end
			end
		end
	end

	// Offers one matrix from this falling edge and returns at the falling edge after the
	// rising edge that took it.
	task automatic send_matrix(mat_t m);
		in_valid <= 1'b1;
		in_mat <= m;
		do begin
			@(negedge clk);
		end while (!in_fire);
	endtask

	task automatic idle_input(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic mat_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
		mat_t m;
		m = '0;
		m[0] = d0;
		m[4] = d1;
		m[8] = d2;
		return m;
	endfunction

	// Signed value in a small range around zero, with a random fraction.
	function automatic logic [31:0] small_elem(int span);
		return 32'($signed($urandom_range(0, 2 * span * 65536)) - span * 65536);
	endfunction

	function automatic logic [31:0] corner_elem();
		case ($urandom_range(0, 7))
			0: return EMAX;
			1: return EMIN;
			2: return 32'h0;
			3: return 32'h1;
			4: return 32'hFFFF_FFFF;
			5: return ONE;
			6: return -ONE;
			default: return $urandom;
		endcase
	endfunction

	// One random matrix; most are well conditioned, the rest probe singular and extreme cases.
	function automatic mat_t random_matrix();
		mat_t m;
		int kind;
		kind = $urandom_range(0, 9);
		for (int k = 0; k < 9; k++) begin
			case (kind)
				0, 1: m[k] = $urandom;
				6: m[k] = corner_elem();
				7: m[k] = small_elem(1);
				default: m[k] = small_elem(8);
			endcase
		end
		if (kind == 5) begin
			// Singular by construction: one row repeats another.
			for (int j = 0; j < 3; j++) begin
				m[6 + j] = m[j];
			end
		end else if (kind == 7) begin
			// Diagonal dominant, so the inverse stays well inside range.
			m[0] = 32'($signed(m[0]) + 4 * 65536);
			m[4] = 32'($signed(m[4]) - 4 * 65536);
			m[8] = 32'($signed(m[8]) + 4 * 65536);
		end
		return m;
	endfunction

	initial begin
		mat_t dir[$];
		mat_t m;
		sb = new();
		mismatches = 0;
		cycles = 0;
		hold_cycles = 0;
		quiet = 1'b0;
		in_fire = 1'b0;
		in_valid = 1'b0;
		in_mat = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed matrices: unit and scaled diagonals, singular, extremes and overflow.
		dir = {dir, diag(ONE, ONE, ONE)};
		dir = {dir, diag(-ONE, -ONE, -ONE)};
		dir = {dir, mat_t'('0)};
		dir = {dir, mat_t'({9{EMAX}})};
		dir = {dir, mat_t'({9{EMIN}})};
		dir = {dir, diag(32'h1, 32'h1, 32'h1)};
		dir = {dir, diag(2 * ONE, ONE / 2, -4 * ONE)};
		dir = {dir, diag(EMAX, EMIN, EMAX)};
		dir = {dir, diag(ONE, ONE, 32'h1)};
		dir = {dir, diag(EMIN, EMIN, EMIN)};
		dir = {dir, mat_t'({9{32'hAAAA_AAAA}})};
		m = '0;
		m[1] = ONE;
		m[3] = ONE;
		m[8] = ONE;
		dir = {dir, m};
		// The classic integer matrix with determinant one.
		m = {32'h0, 6 * ONE, 5 * ONE, 4 * ONE, ONE, 32'h0, 3 * ONE, 2 * ONE, ONE};
		dir = {dir, m};
		// A matrix whose middle column is zero but for its centre element.
		m = {ONE, 32'h0, ONE, 32'h0, ONE, 2 * ONE, ONE, 32'h0, 3 * ONE};
		dir = {dir, m};
		m = {32'h5555_5555, EMAX, 32'h0, EMIN, 32'hAAAA_AAAA, 32'h1,
			32'hFFFF_FFFF, 32'h0, EMAX};
		dir = {dir, m};
		m = diag(3 * ONE, 3 * ONE, 3 * ONE);
		m[2] = ONE;
		m[5] = 2 * ONE;
		m[6] = -ONE;
		dir = {dir, m};
		foreach (dir[i]) begin
			send_matrix(dir[i]);
			idle_input(gap_len());
		end

		for (int n = 0; n < 1150; n++) begin
			if (n == 300) begin
				// Hold the output long enough that the pipeline fills and stalls its input.
				hold_cycles = 200;
			end
			if (n == 600) begin
				idle_input(1);
				wait_drained();
			end
			quiet = (n >= 800 && n < 900);
			send_matrix(random_matrix());
			if (!(n >= 300 && n < 400) && !quiet) begin
				idle_input(gap_len());
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		wait_drained();
		repeat (60) @(negedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
